// ----- src/apu_pkg.sv -----
package apu_pkg;

    // pipeline depth: one capture stage, then the divider stages
    localparam int NUM_STG   = 5;
    localparam int NUM_LANES = 3;
    localparam int NUM_W     = 16;
    localparam int DIV_STEP  = NUM_W / (NUM_STG - 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_ORDER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT     = 2'd2;

    localparam logic MODE_PREMUL   = 1'b0;
    localparam logic MODE_UNPREMUL = 1'b1;

    localparam logic ORDER_ARGB = 1'b0;
    localparam logic ORDER_BGRA = 1'b1;

    typedef struct packed {
        logic mode;
        logic conv;
    } apu_ctl_t;

    typedef struct packed {
        logic [7:0]       rem;
        logic [NUM_W-1:0] num;
        logic [7:0]       quo;
    } apu_div_t;

endpackage

// ----- src/apu_if.sv -----
interface apu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte0;
    logic [7:0] in_byte1;
    logic [7:0] in_byte2;
    logic [7:0] in_byte3;

    modport source (output valid, in_byte0, in_byte1, in_byte2, in_byte3, input ready);
    modport sink   (input valid, in_byte0, in_byte1, in_byte2, in_byte3, output ready);
endinterface

interface apu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte0;
    logic [7:0] out_byte1;
    logic [7:0] out_byte2;
    logic [7:0] out_byte3;

    modport source (output valid, out_byte0, out_byte1, out_byte2, out_byte3, input ready);
    modport sink   (input valid, out_byte0, out_byte1, out_byte2, out_byte3, output ready);
endinterface

interface apu_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [apu_pkg::CFG_IDX_W-1:0]    index;
    logic [apu_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/apu_lane.sv -----
module apu_lane (
    input  logic                          clk,
    input  logic [apu_pkg::NUM_STG-1:0]   en,
    input  logic [7:0]                    alpha,
    input  logic [7:0]                    colour,
    input  apu_pkg::apu_ctl_t             ctl,
    output logic [7:0]                    res
);

    localparam int LAST = apu_pkg::NUM_STG - 1;

    logic [7:0]                   a_reg    [apu_pkg::NUM_STG];
    logic [7:0]                   c_reg    [apu_pkg::NUM_STG];
    apu_pkg::apu_ctl_t            ctl_reg  [apu_pkg::NUM_STG];
    apu_pkg::apu_div_t            div_reg  [apu_pkg::NUM_STG];
    apu_pkg::apu_div_t            div_next [1:apu_pkg::NUM_STG-1];
    logic [7:0]                   pm_reg   [1:apu_pkg::NUM_STG-1];
    logic [apu_pkg::NUM_W-1:0]    prod_reg;
    logic [apu_pkg::NUM_W-1:0]    prod_next;
    logic [apu_pkg::NUM_W-1:0]    num_next;
    logic [7:0]                   pm_next;
    logic [apu_pkg::NUM_W:0]      pm_sum;

    // a*c + 254 stays below 2^16
    assign prod_next = apu_pkg::NUM_W'({8'h00, alpha} * {8'h00, colour})
                     + apu_pkg::NUM_W'(254);
    // c*255 as c*256 - c
    assign num_next  = {colour, 8'h00} - {8'h00, colour};

    // x/255 for x below 65535 as (x + (x>>8) + 1) >> 8
    assign pm_sum  = {1'b0, prod_reg} + {9'h000, prod_reg[apu_pkg::NUM_W-1:8]}
                   + (apu_pkg::NUM_W+1)'(1);
    assign pm_next = pm_sum[15:8];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            a_reg[0]   <= alpha;
            c_reg[0]   <= colour;
            ctl_reg[0] <= ctl;
            prod_reg   <= prod_next;
            div_reg[0] <= '{rem: 8'h00, num: num_next, quo: 8'h00};
        end
    end

    for (genvar s = 1; s < apu_pkg::NUM_STG; s++)
    begin : g_stg
        // restoring division, DIV_STEP quotient bits per stage
        always_comb
        begin
            logic [8:0] r9;
            logic       qb;
            div_next[s] = div_reg[s-1];
            for (int i = 0; i < apu_pkg::DIV_STEP; i++)
            begin
                r9 = {div_next[s].rem, div_next[s].num[apu_pkg::NUM_W-1]};
                div_next[s].num = {div_next[s].num[apu_pkg::NUM_W-2:0], 1'b0};
                if (r9 >= {1'b0, a_reg[s-1]})
                begin
                    div_next[s].rem = 8'(r9 - {1'b0, a_reg[s-1]});
                    qb = 1'b1;
                end
                else
                begin
                    div_next[s].rem = r9[7:0];
                    qb = 1'b0;
                end
                div_next[s].quo = {div_next[s].quo[6:0], qb};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[s])
            begin
                a_reg[s]   <= a_reg[s-1];
                c_reg[s]   <= c_reg[s-1];
                ctl_reg[s] <= ctl_reg[s-1];
                div_reg[s] <= div_next[s];
            end
        end

        if (s == 1)
        begin : g_pm_first
            always_ff @(posedge clk)
            begin
                if (en[s])
                    pm_reg[s] <= pm_next;
            end
        end
        else
        begin : g_pm_pass
            always_ff @(posedge clk)
            begin
                if (en[s])
                    pm_reg[s] <= pm_reg[s-1];
            end
        end
    end

    always_comb
    begin
        if (!ctl_reg[LAST].conv)
            res = c_reg[LAST];
        else if (ctl_reg[LAST].mode == apu_pkg::MODE_PREMUL)
            res = pm_reg[LAST];
        else if (a_reg[LAST] == 8'h00)
            res = c_reg[LAST];
        else
            res = div_reg[LAST].quo;
    end

endmodule

// ----- src/apu_merge.sv -----
module apu_merge (
    input  logic                              order,
    input  logic [7:0]                        alpha,
    input  logic [apu_pkg::NUM_LANES-1:0][7:0] lane_res,
    output logic [3:0][7:0]                   pix
);

    // put the colour lanes back around alpha in memory order
    always_comb
    begin
        case (order)
            apu_pkg::ORDER_BGRA:
            begin
                pix[0] = lane_res[0];
                pix[1] = lane_res[1];
                pix[2] = lane_res[2];
                pix[3] = alpha;
            end
            default:
            begin
                pix[0] = alpha;
                pix[1] = lane_res[0];
                pix[2] = lane_res[1];
                pix[3] = lane_res[2];
            end
        endcase
    end

endmodule

// ----- src/alpha_premultiply_unpremultiply.sv -----
// Alpha premultiply / unpremultiply for one 32-bit pixel per transfer.
// pixel: input channel, four bytes in memory order; result: output channel,
// the converted bytes in the same order; cfg: register writes, index 0 mode
// (0 premultiply, 1 unpremultiply), 1 byte order (0 A,R,G,B, 1 B,G,R,A),
// 2 format (1 convert, 0 pass through). Only data bit 0 is used, other
// indexes are dropped; cfg is always ready. Write cfg only while idle.
// Three colour lanes run side by side, alpha travels beside them and the
// merge puts the bytes back in place.
// Throughput is one pixel per cycle while result is not stalled, set by the
// 5-stage lane pipeline: a capture stage with the 8x8 multiply, then four
// stages of a restoring divider at four quotient bits each.
// Each stage moves on when the next one is empty or moving, so a stalled
// result only holds the stages behind it once they fill up; bubbles close.
// Reset clears all valid bits and sets mode 0, byte order 1, format 1.
module alpha_premultiply_unpremultiply (
    input  logic      clk,
    input  logic      rst_n,
    apu_in_if.sink    pixel,
    apu_out_if.source result,
    apu_cfg_if.sink   cfg
);

    localparam int LAST = apu_pkg::NUM_STG - 1;

    logic                                mode_reg;
    logic                                order_reg;
    logic                                format_reg;
    logic [apu_pkg::NUM_STG-1:0]         valid_reg;
    logic [apu_pkg::NUM_STG-1:0]         order_pipe_reg;
    logic [7:0]                          alpha_reg [apu_pkg::NUM_STG];
    logic [apu_pkg::NUM_STG-1:0]         en;
    logic [7:0]                          in_alpha;
    logic [apu_pkg::NUM_LANES-1:0][7:0]  in_colour;
    logic [apu_pkg::NUM_LANES-1:0][7:0]  lane_res;
    logic [3:0][7:0]                     pix;
    apu_pkg::apu_ctl_t                   in_ctl;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= apu_pkg::MODE_PREMUL;
            order_reg  <= apu_pkg::ORDER_BGRA;
            format_reg <= 1'b1;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                apu_pkg::CFG_MODE:       mode_reg   <= cfg.data[0];
                apu_pkg::CFG_BYTE_ORDER: order_reg  <= cfg.data[0];
                apu_pkg::CFG_FORMAT:     format_reg <= cfg.data[0];
                default:                 ;
            endcase
        end
    end

    // stage enables, back to front
    always_comb
    begin
        en[LAST] = !valid_reg[LAST] || result.ready;
        for (int s = LAST - 1; s >= 0; s--)
            en[s] = !valid_reg[s] || en[s+1];
    end

    assign pixel.ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (en[0])
                valid_reg[0] <= pixel.valid;
            for (int s = 1; s < apu_pkg::NUM_STG; s++)
                if (en[s])
                    valid_reg[s] <= valid_reg[s-1];
        end
    end

    always_comb
    begin
        case (order_reg)
            apu_pkg::ORDER_BGRA:
            begin
                in_alpha     = pixel.in_byte3;
                in_colour[0] = pixel.in_byte0;
                in_colour[1] = pixel.in_byte1;
                in_colour[2] = pixel.in_byte2;
            end
            default:
            begin
                in_alpha     = pixel.in_byte0;
                in_colour[0] = pixel.in_byte1;
                in_colour[1] = pixel.in_byte2;
                in_colour[2] = pixel.in_byte3;
            end
        endcase
    end

    assign in_ctl = '{mode: mode_reg, conv: format_reg};

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            alpha_reg[0]      <= in_alpha;
            order_pipe_reg[0] <= order_reg;
        end
        for (int s = 1; s < apu_pkg::NUM_STG; s++)
            if (en[s])
            begin
                alpha_reg[s]      <= alpha_reg[s-1];
                order_pipe_reg[s] <= order_pipe_reg[s-1];
            end
    end

    for (genvar l = 0; l < apu_pkg::NUM_LANES; l++)
    begin : g_lane
        apu_lane u_lane (
            .clk    (clk),
            .en     (en),
            .alpha  (in_alpha),
            .colour (in_colour[l]),
            .ctl    (in_ctl),
            .res    (lane_res[l])
        );
    end

    apu_merge u_merge (
        .order    (order_pipe_reg[LAST]),
        .alpha    (alpha_reg[LAST]),
        .lane_res (lane_res),
        .pix      (pix)
    );

    assign result.valid     = valid_reg[LAST];
    assign result.out_byte0 = pix[0];
    assign result.out_byte1 = pix[1];
    assign result.out_byte2 = pix[2];
    assign result.out_byte3 = pix[3];

`ifndef NO_ASSERTIONS
    a_full_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        ((&valid_reg) && !result.ready) |-> !pixel.ready)
        else $error("input taken while pipeline full and stalled");

    a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg == '0) |-> pixel.ready)
        else $error("empty pipeline refuses input");

    a_alpha_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && order_pipe_reg[LAST] == apu_pkg::ORDER_BGRA)
        |-> (result.out_byte3 == alpha_reg[LAST]))
        else $error("alpha byte altered");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |=> (valid_reg[LAST] && $stable(pix)))
        else $error("stalled result changed");
`endif

endmodule
